### sv/websocket_frame_deframer_assert.svh
// Assertion macros shared by the deframer modules.
// Each use checks on the rising edge of clock and is quiet while reset is high.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define WSDF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WSDF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/wsdf_pkg.sv
`default_nettype none

package wsdf_pkg;

   // Parser phase, one-hot
   typedef enum logic [8:0] {
      PH_HDR0  = 9'b000000001,
      PH_HDR1  = 9'b000000010,
      PH_EXT0  = 9'b000000100,
      PH_EXT1  = 9'b000001000,
      PH_MASK0 = 9'b000010000,
      PH_MASK1 = 9'b000100000,
      PH_MASK2 = 9'b001000000,
      PH_MASK3 = 9'b010000000,
      PH_DATA  = 9'b100000000
   } phase_type;

   // Result kinds
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   // Opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;

   // Length codes in the second header byte
   localparam logic [6:0] LEN_EXT16  = 7'd126;
   localparam logic [6:0] LEN_EXT64  = 7'd127;

   // Close status codes
   localparam logic [15:0] CLOSE_NORMAL      = 16'd1000;
   localparam logic [15:0] CLOSE_UNSUPPORTED = 16'd1003;
   localparam logic [15:0] CLOSE_TOO_BIG     = 16'd1009;

   // One result transaction
   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  payload_byte;
      logic        frame_last;
      logic [15:0] close_code;
   } rsp_type;

endpackage

`default_nettype wire

### sv/websocket_frame_deframer.sv
// A result is registered in the output register, or first in the skid register while rsp_stall holds it.
// Throughput: one byte per cycle while req_stall is low; the parser state and a two-entry output stage
// (result register plus skid register) set this, so bytes keep flowing while a result waits.
// req_stall rises only while the skid register is occupied.
// Reset (synchronous, active high) returns the parser to the first header byte
// and empties the output stage.
`default_nettype none

`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_frame_last,
   output logic [15:0]      rsp_close_code
);
   import wsdf_pkg::*;

   logic    rsp_valid_ff,  rsp_valid_in;
   rsp_type rsp_ff,        rsp_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff,       skid_in;
   logic    req_take;
   logic    rsp_take;
   rsp_type new_res;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   wsdf_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_take),
      .in_byte (req_in_byte),
      .result  (new_res)
   );

   // Steer a new result or the parked skid entry into the output register, or park a new result in the skid register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = new_res.valid;
            rsp_in       = new_res;
         end
      end else if (new_res.valid) begin
         skid_valid_in = 1'b1;
         skid_in       = new_res;
      end
   end

   // Clear control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_frame_last   = rsp_ff.frame_last;
   assign rsp_close_code   = rsp_ff.close_code;

   `WSDF_ASSERT_NOW(a_skid_needs_rsp, skid_valid_ff, rsp_valid_ff, "skid register full while output register empty")
   `WSDF_ASSERT_NEXT(a_skid_holds, skid_valid_ff && !rsp_take, skid_valid_ff, "skid transaction dropped while output stalled")
   `WSDF_ASSERT_NOW(a_close_fields, rsp_valid_ff && (rsp_ff.kind == KIND_CLOSE), (rsp_ff.payload_byte == 8'd0) && (rsp_ff.frame_last == 1'b0), "close transaction carries payload fields")
   `WSDF_ASSERT_NOW(a_data_fields, rsp_valid_ff && (rsp_ff.kind == KIND_DATA), rsp_ff.close_code == 16'd0, "payload transaction carries a close code")

endmodule

`default_nettype wire

### sv/wsdf_parse.sv
`default_nettype none

`include "websocket_frame_deframer_assert.svh"

module wsdf_parse (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire logic [7:0]       in_byte,
   output wsdf_pkg::rsp_type     result
);
   import wsdf_pkg::*;

   phase_type   phase_ff,        phase_in;
   logic [3:0]  frame_opcode_ff, frame_opcode_in;
   logic [15:0] frame_length_ff, frame_length_in;
   logic [15:0] bytes_seen_ff,   bytes_seen_in;
   logic [31:0] mask_key_ff,     mask_key_in;
   rsp_type     res;

   logic [15:0] seen_inc;
   logic        last_byte;
   logic        data_opcode;
   logic [7:0]  mask_byte;
   logic [7:0]  plain;

   // Pick the mask byte for this payload position
   always_comb begin
      case (bytes_seen_ff[1:0])
         2'd0:    mask_byte = mask_key_ff[31:24];
         2'd1:    mask_byte = mask_key_ff[23:16];
         2'd2:    mask_byte = mask_key_ff[15:8];
         default: mask_byte = mask_key_ff[7:0];
      endcase
   end

   assign plain       = in_byte ^ mask_byte;
   assign seen_inc    = bytes_seen_ff + 16'd1;
   assign last_byte   = (seen_inc == frame_length_ff);
   assign data_opcode = (frame_opcode_ff == OP_CONT) || (frame_opcode_ff == OP_BINARY);

   // Advance the parser by one byte
   always_comb begin
      phase_in        = phase_ff;
      frame_opcode_in = frame_opcode_ff;
      frame_length_in = frame_length_ff;
      bytes_seen_in   = bytes_seen_ff;
      mask_key_in     = mask_key_ff;
      res             = '0;

      case (phase_ff)
         PH_HDR1: begin
            if (in_byte[6:0] == LEN_EXT64) begin
               phase_in       = PH_HDR0;
               res.valid      = 1'b1;
               res.kind       = KIND_CLOSE;
               res.close_code = CLOSE_TOO_BIG;
            end else if (in_byte[6:0] == LEN_EXT16) begin
               phase_in = PH_EXT0;
            end else begin
               frame_length_in = {9'd0, in_byte[6:0]};
               phase_in        = PH_MASK0;
            end
         end
         PH_EXT0: begin
            frame_length_in = {in_byte, 8'h00};
            phase_in        = PH_EXT1;
         end
         PH_EXT1: begin
            frame_length_in = frame_length_ff | {8'h00, in_byte};
            phase_in        = PH_MASK0;
         end
         PH_MASK0, PH_MASK1, PH_MASK2, PH_MASK3: begin
            mask_key_in   = {mask_key_ff[23:0], in_byte};
            bytes_seen_in = 16'd0;
            if (phase_ff == PH_MASK0) begin
               phase_in = PH_MASK1;
            end else if (phase_ff == PH_MASK1) begin
               phase_in = PH_MASK2;
            end else if (phase_ff == PH_MASK2) begin
               phase_in = PH_MASK3;
            end else if (frame_length_ff == 16'd0) begin
               // Empty frame ends straight after the mask
               phase_in = PH_HDR0;
               if (!data_opcode) begin
                  res.valid      = 1'b1;
                  res.kind       = KIND_CLOSE;
                  res.close_code = (frame_opcode_ff == OP_CLOSE) ? CLOSE_NORMAL
                                                                  : CLOSE_UNSUPPORTED;
               end
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            bytes_seen_in = seen_inc;
            if (data_opcode) begin
               res.valid        = 1'b1;
               res.kind         = KIND_DATA;
               res.payload_byte = plain;
               res.frame_last   = last_byte;
            end else if (last_byte) begin
               res.valid      = 1'b1;
               res.kind       = KIND_CLOSE;
               res.close_code = (frame_opcode_ff == OP_CLOSE) ? CLOSE_NORMAL
                                                               : CLOSE_UNSUPPORTED;
            end
            if (last_byte) begin
               phase_in      = PH_HDR0;
               bytes_seen_in = 16'd0;
            end
         end
         default: begin
            // First header byte, and any stray phase code
            frame_opcode_in = in_byte[3:0];
            phase_in        = PH_HDR1;
         end
      endcase
   end

   assign result = step_en ? res : '0;

   // Update parser state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         frame_opcode_ff <= 4'h0;
         frame_length_ff <= 16'd0;
         bytes_seen_ff   <= 16'd0;
         mask_key_ff     <= 32'd0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         frame_opcode_ff <= frame_opcode_in;
         frame_length_ff <= frame_length_in;
         bytes_seen_ff   <= bytes_seen_in;
         mask_key_ff     <= mask_key_in;
      end
   end

   `WSDF_ASSERT_NEXT(a_last_to_header, result.valid && (result.kind == KIND_DATA) && result.frame_last, phase_ff == PH_HDR0, "last payload byte did not return to header")
   `WSDF_ASSERT_NEXT(a_close_to_header, result.valid && (result.kind == KIND_CLOSE), phase_ff == PH_HDR0, "close result did not return to header")
   `WSDF_ASSERT_NEXT(a_hold_when_idle, !step_en, $stable(phase_ff) && $stable(bytes_seen_ff), "parser state moved without a byte")

endmodule

`default_nettype wire

### tb/tb_websocket_frame_deframer.sv
module tb_websocket_frame_deframer;
   import wsdf_pkg::*;

   localparam int RANDOM_ITEMS     = 500;
   localparam int TAIL_ITEMS       = 80;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int IDLE_LIMIT       = 2000;
   localparam int DIRECTED_ROWS    = 24;

   // One result transaction as seen on the rsp_ channel
   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic        frame_last;
      logic [15:0] close_code;
   } deframed_type;

   // One row of directed stimulus; typed rows carry their result, the rest use the predictor
   typedef struct packed {
      logic [7:0]   in_byte;
      logic         typed;
      logic         has_rsp;
      deframed_type rsp;
   } stim_row_type;

   localparam deframed_type NONE = '0;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic [7:0]  req_in_byte  = 8'h00;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_frame_last;
   logic [15:0] rsp_close_code;

   logic        tail_phase      = 1'b0;
   logic        long_hold_start = 1'b0;
   logic        long_hold_taken = 1'b0;
   int          stall_left      = 0;
   int          mismatches      = 0;
   int          idle_cycles     = 0;

   deframed_type expected_results[$];

   // Predicted parser state
   phase_type   parse_phase = PH_HDR0;
   logic [3:0]  frame_op    = OP_CONT;
   logic [15:0] frame_len   = '0;
   logic [15:0] frame_pos   = '0;
   logic [31:0] frame_mask  = '0;

   // Refused length, empty close frame, one-byte binary frame, unknown opcode with ext length
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h0F, 1'b1, 1'b0, NONE},
      '{8'hFF, 1'b1, 1'b1, deframed_type'{KIND_CLOSE, 8'h00, 1'b0, CLOSE_TOO_BIG}},
      '{8'h88, 1'b1, 1'b0, NONE},
      '{8'h80, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'hA5, 1'b0, 1'b0, NONE},
      '{8'h5A, 1'b1, 1'b1, deframed_type'{KIND_CLOSE, 8'h00, 1'b0, CLOSE_NORMAL}},
      '{8'h82, 1'b0, 1'b0, NONE},
      '{8'h81, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b1, 1'b1, deframed_type'{KIND_DATA, 8'h00, 1'b1, 16'd0}},
      '{8'hF1, 1'b0, 1'b0, NONE},
      '{8'h7E, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'h01, 1'b0, 1'b0, NONE},
      '{8'h12, 1'b0, 1'b0, NONE},
      '{8'h34, 1'b0, 1'b0, NONE},
      '{8'h56, 1'b0, 1'b0, NONE},
      '{8'h78, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b1, 1'b1, deframed_type'{KIND_CLOSE, 8'h00, 1'b0, CLOSE_UNSUPPORTED}}
   };

   websocket_frame_deframer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_close_code   (rsp_close_code)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Close the frame: streamed opcodes end silently, close gives normal, others unsupported
   task automatic end_frame(output bit produced, output deframed_type r);
      r            = '0;
      parse_phase  = PH_HDR0;
      frame_pos    = '0;
      produced     = !(frame_op == OP_CONT || frame_op == OP_BINARY);
      r.kind       = KIND_CLOSE;
      r.close_code = (frame_op == OP_CLOSE) ? CLOSE_NORMAL : CLOSE_UNSUPPORTED;
   endtask

   // Advance the predicted parser by one received byte
   task automatic deframe_byte(input logic [7:0] b, output bit produced,
                               output deframed_type r);
      logic [7:0] plain;
      logic       last;
      produced = 1'b0;
      r        = '0;
      case (parse_phase)
         PH_HDR1: begin
            if (b[6:0] == LEN_EXT64) begin
               parse_phase  = PH_HDR0;
               produced     = 1'b1;
               r.kind       = KIND_CLOSE;
               r.close_code = CLOSE_TOO_BIG;
            end else if (b[6:0] == LEN_EXT16) begin
               parse_phase = PH_EXT0;
            end else begin
               frame_len   = {9'd0, b[6:0]};
               parse_phase = PH_MASK0;
            end
         end
         PH_EXT0: begin
            frame_len   = {b, 8'h00};
            parse_phase = PH_EXT1;
         end
         PH_EXT1: begin
            frame_len[7:0] = b;
            parse_phase    = PH_MASK0;
         end
         PH_MASK0, PH_MASK1, PH_MASK2, PH_MASK3: begin
            frame_mask = {frame_mask[23:0], b};
            frame_pos  = '0;
            case (parse_phase)
               PH_MASK0: parse_phase = PH_MASK1;
               PH_MASK1: parse_phase = PH_MASK2;
               PH_MASK2: parse_phase = PH_MASK3;
               default: begin
                  if (frame_len == 16'd0) end_frame(produced, r);
                  else parse_phase = PH_DATA;
               end
            endcase
         end
         PH_DATA: begin
            plain     = b ^ frame_mask[8 * (3 - int'(frame_pos[1:0])) +: 8];
            frame_pos = frame_pos + 16'd1;
            last      = (frame_pos == frame_len);
            if (frame_op == OP_CONT || frame_op == OP_BINARY) begin
               produced       = 1'b1;
               r.kind         = KIND_DATA;
               r.payload_byte = plain;
               r.frame_last   = last;
               if (last) begin
                  parse_phase = PH_HDR0;
                  frame_pos   = '0;
               end
            end else if (last) begin
               end_frame(produced, r);
            end
         end
         default: begin
            frame_op    = b[3:0];
            parse_phase = PH_HDR1;
         end
      endcase
   endtask

   // Pick the next stream byte to suit the predicted phase, so most frames are well formed
   function automatic logic [7:0] stream_byte();
      int         pick;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      b    = 8'($urandom);
      case (parse_phase)
         PH_HDR0: begin
            if (pick < 40)      b[3:0] = OP_BINARY;
            else if (pick < 65) b[3:0] = OP_CONT;
            else if (pick < 75) b[3:0] = OP_CLOSE;
         end
         PH_HDR1: begin
            if (pick < 8)       b[6:0] = LEN_EXT64;
            else if (pick < 22) b[6:0] = LEN_EXT16;
            else if (pick < 30) b[6:0] = 7'd0;
            else if (pick < 34) b[6:0] = 7'($urandom_range(100, 125));
            else                b[6:0] = 7'($urandom_range(1, 24));
         end
         PH_EXT0: b = (pick < 4) ? 8'h01 : 8'h00;
         PH_EXT1: if (pick < 70) b = 8'($urandom_range(0, 20));
         default: ;
      endcase
      return b;
   endfunction

   // Offer one byte, with an occasional idle burst first, and predict once it is taken
   task automatic send_byte(input logic [7:0] b, input bit may_idle,
                            output bit produced, output deframed_type r);
      if (may_idle && !tail_phase && $urandom_range(0, 7) == 0) begin
         req_valid   <= 1'b0;
         req_in_byte <= 8'($urandom);
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      deframe_byte(b, produced, r);
   endtask

   // Hold the sender until every predicted result has come out
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   initial begin
      bit           produced;
      deframed_type r;
      logic [7:0]   b;
      int           sent;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].in_byte, 1'b1, produced, r);
         if (directed_rows[i].typed) begin
            if (directed_rows[i].has_rsp) expected_results.push_back(directed_rows[i].rsp);
         end else if (produced) begin
            expected_results.push_back(r);
         end
      end
      drain();

      // Stream a 20-byte binary frame into a receiver that holds off for a long stretch
      long_hold_start <= 1'b1;
      for (int k = 0; k < 26; k++) begin
         b = (k == 0) ? 8'h82 : (k == 1) ? 8'h94 : 8'($urandom);
         send_byte(b, 1'b0, produced, r);
         if (produced) expected_results.push_back(r);
      end

      // Random stream, with no idling on either side at the end
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == RANDOM_ITEMS - TAIL_ITEMS) tail_phase <= 1'b1;
         send_byte(stream_byte(), 1'b1, produced, r);
         if (produced) expected_results.push_back(r);
         sent++;
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Check each result transaction and drive the receiver's stall
   always @(posedge clock) begin
      deframed_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind %0d, payload_byte %0h, frame_last %0d, close_code %0d",
                      rsp_kind, rsp_payload_byte, rsp_frame_last, rsp_close_code);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  mismatches++;
               end
               if (rsp_payload_byte !== want.payload_byte) begin
                  $error("payload_byte: expected %0h, got %0h", want.payload_byte, rsp_payload_byte);
                  mismatches++;
               end
               if (rsp_frame_last !== want.frame_last) begin
                  $error("frame_last: expected %0d, got %0d", want.frame_last, rsp_frame_last);
                  mismatches++;
               end
               if (rsp_close_code !== want.close_code) begin
                  $error("close_code: expected %0d, got %0d", want.close_code, rsp_close_code);
                  mismatches++;
               end
            end
         end

         // Hold off once for a long stretch when asked, otherwise stall in short bursts
         if (long_hold_start && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            stall_left      = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && !tail_phase && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6);
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Give up when no transaction moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
